@@ rtl/scg_pkg.sv @@
package scg_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int MODE_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [MODE_W-1:0] mode_t;

  // generator select codes; any other code selects ccitt
  localparam mode_t MODE_CRC12 = 2'd0;
  localparam mode_t MODE_CRC16 = 2'd1;
  localparam mode_t MODE_CCITT = 2'd2;

  localparam mode_t MODE_RESET = MODE_CCITT;

  // generator polynomials without the leading term
  localparam crc_t POLY_CRC12 = 16'h080F;
  localparam crc_t POLY_CRC16 = 16'h8005;
  localparam crc_t POLY_CCITT = 16'h1021;

  localparam crc_t MASK_CRC12 = 16'h0FFF;
  localparam crc_t MASK_CRC16 = 16'hFFFF;

endpackage

@@ rtl/scg_if.sv @@
interface scg_msg_if;
  import scg_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface scg_crc_if;
  import scg_pkg::*;

  logic valid;
  logic ready;
  crc_t crc_value;
  logic crc_final;

  modport source (output valid, output crc_value, output crc_final, input ready);
  modport sink   (input valid, input crc_value, input crc_final, output ready);
endinterface

interface scg_cfg_if;
  import scg_pkg::*;

  logic  valid;
  logic  ready;
  mode_t crc_mode;

  modport source (output valid, output crc_mode, input ready);
  modport sink   (input valid, input crc_mode, output ready);
endinterface

@@ rtl/scg_byte_step.sv @@
module scg_byte_step (
  input  scg_pkg::mode_t crc_mode,
  input  scg_pkg::crc_t  rem_in,
  input  scg_pkg::byte_t data_byte,
  output scg_pkg::crc_t  rem_out
);
  import scg_pkg::*;

  crc_t poly;
  crc_t mask;
  logic is_crc12;

  always_comb begin
    case (crc_mode)
      MODE_CRC12: begin
        poly = POLY_CRC12;
        mask = MASK_CRC12;
      end
      MODE_CRC16: begin
        poly = POLY_CRC16;
        mask = MASK_CRC16;
      end
      default: begin
        poly = POLY_CCITT;
        mask = MASK_CRC16;
      end
    endcase
  end

  assign is_crc12 = (crc_mode == MODE_CRC12);

  // eight unrolled lfsr steps, msb of the byte first
  always_comb begin
    crc_t r;
    logic top;
    r = rem_in & mask;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      top = is_crc12 ? r[11] : r[CRC_W-1];
      r   = {r[CRC_W-2:0], 1'b0} & mask;
      if (top ^ data_byte[i]) begin
        r = r ^ poly;
      end
    end
    rem_out = r;
  end

endmodule

@@ rtl/selectable_crc_generator_core.sv @@
// selectable crc generator: running crc-12 / crc-16 / crc-ccitt over a byte stream
//
// msg channel: one byte per beat, msb first, last_byte marks the end of a message
// crc channel: one beat per message byte carrying the remainder so far;
//   crc_final echoes last_byte, crc-12 results sit in the low 12 bits
// cfg channel: writes the 2-bit generator select, always ready; write it only
//   while no byte is in flight (codes other than 0 and 1 select ccitt)
// latency: a byte accepted at edge n shows on the crc channel after edge n+1
//   (input register, then the result register) and can leave at edge n+2
// throughput: one byte per cycle; the remainder update is a single pass of
//   eight unrolled lfsr steps between the input register and the result register
// stalls: when the crc receiver holds ready low the result register keeps its
//   beat, the input register fills, and msg ready drops until the result leaves
// reset: both registers empty, remainder zero, generator select ccitt
// after a beat with last_byte set the remainder returns to zero
module selectable_crc_generator_core (
  input logic      clk,
  input logic      rst,
  scg_msg_if.sink   msg,
  scg_crc_if.source crc,
  scg_cfg_if.sink   cfg
);
  import scg_pkg::*;

  // generator select register
  mode_t crc_mode;

  // input register
  logic  in_valid;
  byte_t in_byte;
  logic  in_last;

  // running remainder and result register
  crc_t  remainder_reg;
  crc_t  rem_next;
  logic  out_valid;
  crc_t  out_value;
  logic  out_final;

  logic  advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= MODE_RESET;
    end else if (cfg.valid) begin
      crc_mode <= cfg.crc_mode;
    end
  end

  // input register moves on when the result register is free or draining
  assign advance   = in_valid && (!out_valid || crc.ready);
  assign msg.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg.ready) begin
      in_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      in_byte <= msg.data_byte;
      in_last <= msg.last_byte;
    end
  end

  scg_byte_step u_step (
    .crc_mode  (crc_mode),
    .rem_in    (remainder_reg),
    .data_byte (in_byte),
    .rem_out   (rem_next)
  );

  // remainder clears after the last byte of a message
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder_reg <= '0;
    end else if (advance) begin
      remainder_reg <= in_last ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (crc.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= rem_next;
      out_final <= in_last;
    end
  end

  assign crc.valid     = out_valid;
  assign crc.crc_value = out_value;
  assign crc.crc_final = out_final;

  // a finished message leaves a zero remainder behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (remainder_reg == '0))
    else $error("remainder not cleared after last byte");

  // crc-12 results never set the upper four bits
  a_crc12_width: assert property (@(posedge clk) disable iff (rst)
    (advance && crc_mode == MODE_CRC12) |=> (crc.crc_value[CRC_W-1:12] == 4'd0))
    else $error("crc-12 result wider than 12 bits");

  // an accepted byte always lands in the input register
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (msg.valid && msg.ready) |=> in_valid)
    else $error("accepted byte lost");

  // a result comes out only after a byte went through the step logic
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result without a computed byte");

endmodule
